/* src/assert_macros.svh */
// Assertion helpers: clocked on clk, muted while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* src/tll_pkg.sv */
`default_nettype none

package tll_pkg;

  // Token class codes
  localparam logic [2:0] KIND_WS      = 3'd0;
  localparam logic [2:0] KIND_NUM     = 3'd1;
  localparam logic [2:0] KIND_IDENT   = 3'd2;
  localparam logic [2:0] KIND_STR     = 3'd3;
  localparam logic [2:0] KIND_SYM     = 3'd4;
  localparam logic [2:0] KIND_COMMENT = 3'd5;

  // Characters of interest
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Result queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_INT     = 7'b0000010,
    MODE_FRAC    = 7'b0000100,
    MODE_IDENT   = 7'b0001000,
    MODE_STR     = 7'b0010000,
    MODE_ESC     = 7'b0100000,
    MODE_COMMENT = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] kind;
    logic       tbeg;
    logic       tend;
    logic       line_done;
  } res_t;

  typedef struct packed {
    res_t  res;
    mode_t mode;
  } cls_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alp(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alp(c) || is_dig(c) || (c == CH_UNDER);
  endfunction

  // Tag character h in mode m, with lookahead n valid when has_n.
  function automatic cls_t classify(mode_t m, logic [7:0] h, logic [7:0] n, logic has_n);
    cls_t o;
    logic cont;
    o.res.ch        = h;
    o.res.kind      = KIND_WS;
    o.res.tbeg      = 1'b0;
    o.res.tend      = 1'b0;
    o.res.line_done = 1'b0;
    o.mode          = m;
    cont            = 1'b1;

    if (m == MODE_INT && is_dig(h)) begin
      o.res.kind = KIND_NUM;
      o.res.tend = !(has_n && (is_dig(n) || n == CH_DOT));
      o.mode     = o.res.tend ? MODE_IDLE : MODE_INT;
    end else if (m == MODE_INT && h == CH_DOT && has_n && is_dig(n)) begin
      o.res.kind = KIND_NUM;
      o.mode     = MODE_FRAC;
    end else if (m == MODE_FRAC && is_dig(h)) begin
      o.res.kind = KIND_NUM;
      o.res.tend = !(has_n && is_dig(n));
      o.mode     = o.res.tend ? MODE_IDLE : MODE_FRAC;
    end else if (m == MODE_IDENT && is_word(h)) begin
      o.res.kind = KIND_IDENT;
      o.res.tend = !(has_n && is_word(n));
      o.mode     = o.res.tend ? MODE_IDLE : MODE_IDENT;
    end else if (m == MODE_STR) begin
      o.res.kind = KIND_STR;
      if (h == CH_QUOTE) begin
        o.res.tend = 1'b1;
        o.mode     = MODE_IDLE;
      end else if (h == CH_BSLASH && has_n) begin
        o.mode = MODE_ESC;
      end else begin
        o.res.tend = !has_n;
      end
    end else if (m == MODE_ESC) begin
      o.res.kind = KIND_STR;
      o.res.tend = !has_n;
      o.mode     = MODE_STR;
    end else if (m == MODE_COMMENT) begin
      o.res.kind = KIND_COMMENT;
    end else begin
      cont = 1'b0;
    end

    // token start position
    if (!cont) begin
      o.mode = MODE_IDLE;
      if (is_ws(h)) begin
        o.res.kind = KIND_WS;
      end else if (h == CH_SLASH && has_n && n == CH_SLASH) begin
        o.res.kind = KIND_COMMENT;
        o.mode     = MODE_COMMENT;
      end else if (is_dig(h) || ((h == CH_PLUS || h == CH_MINUS) && has_n && is_dig(n))) begin
        o.res.kind = KIND_NUM;
        o.res.tbeg = 1'b1;
        o.res.tend = !(has_n && (is_dig(n) || (is_dig(h) && n == CH_DOT)));
        o.mode     = o.res.tend ? MODE_IDLE : MODE_INT;
      end else if (is_alp(h)) begin
        o.res.kind = KIND_IDENT;
        o.res.tbeg = 1'b1;
        o.res.tend = !(has_n && is_word(n));
        o.mode     = o.res.tend ? MODE_IDLE : MODE_IDENT;
      end else if (h == CH_QUOTE) begin
        o.res.kind = KIND_STR;
        o.res.tbeg = 1'b1;
        o.res.tend = !has_n;
        o.mode     = o.res.tend ? MODE_IDLE : MODE_STR;
      end else begin
        o.res.kind = KIND_SYM;
        o.res.tbeg = 1'b1;
        o.res.tend = 1'b1;
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* src/tll_if.sv */
`default_nettype none

interface tll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_line;

  modport source (output valid, in_char, end_of_line, input ready);
  modport sink   (input valid, in_char, end_of_line, output ready);
endinterface

interface tll_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [2:0] token_kind;
  logic       token_begin;
  logic       token_end;
  logic       line_done;

  modport source (output valid, out_char, token_kind, token_begin, token_end, line_done,
                  input ready);
  modport sink   (input valid, out_char, token_kind, token_begin, token_end, line_done,
                  output ready);
endinterface

`default_nettype wire

/* src/template_line_lexer_unit.sv */
// Channel   Dir  Payload                                             Handshake
// in_ch     in   in_char, end_of_line                                valid/ready
// out_ch    out  out_char, token_kind, token_begin, token_end,       valid/ready
//                line_done
//
// One character is taken per clock while the four-entry result queue has two
// free places; each character's tag is decided when the next one arrives.
// A line end yields up to two results, drained one per clock from the queue while out_ch is ready.
// A tag decided by a transfer is written into the result queue, which drives out_ch.
// Synchronous active-low reset empties the queue and returns the lexer to idle.
// Either side may stall at any time; the queue absorbs the difference.
`default_nettype none

module template_line_lexer_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tll_in_if.sink     in_ch,
  tll_out_if.source  out_ch
);

  tll_pkg::mode_t mode_r;
  logic [7:0]     held_char_r;
  logic           held_valid_r;

  tll_pkg::res_t             q_r [tll_pkg::QDEPTH];
  logic [tll_pkg::QAW-1:0]   wr_ptr_r;
  logic [tll_pkg::QAW-1:0]   rd_ptr_r;
  logic [tll_pkg::QAW:0]     count_r;
  logic [tll_pkg::QAW:0]     count_nxt;

  logic           accept;
  logic           pop;
  logic [1:0]     n_push;
  tll_pkg::cls_t  cls0;
  tll_pkg::cls_t  cls1;
  tll_pkg::mode_t mode_mid;
  tll_pkg::res_t  res_last;

  assign in_ch.ready = count_r <= (tll_pkg::QAW+1)'(tll_pkg::QDEPTH - 2);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = count_r != '0;
  assign pop         = out_ch.valid && out_ch.ready;

  always_comb begin
    cls0     = tll_pkg::classify(mode_r, held_char_r, in_ch.in_char, 1'b1);
    mode_mid = held_valid_r ? cls0.mode : mode_r;
    cls1     = tll_pkg::classify(mode_mid, in_ch.in_char, 8'd0, 1'b0);
    res_last = cls1.res;
    res_last.line_done = 1'b1;
    n_push   = accept ? ({1'b0, held_valid_r} + {1'b0, in_ch.end_of_line}) : 2'd0;
    count_nxt = count_r + (tll_pkg::QAW+1)'(n_push) - (tll_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= tll_pkg::MODE_IDLE;
      held_char_r  <= 8'd0;
      held_valid_r <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      if (accept) begin
        if (in_ch.end_of_line) begin
          // line end flushes the held character and resets the mode
          mode_r       <= tll_pkg::MODE_IDLE;
          held_char_r  <= 8'd0;
          held_valid_r <= 1'b0;
        end else begin
          mode_r       <= mode_mid;
          held_char_r  <= in_ch.in_char;
          held_valid_r <= 1'b1;
        end
      end
      wr_ptr_r <= wr_ptr_r + tll_pkg::QAW'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (held_valid_r || in_ch.end_of_line)) begin
      q_r[wr_ptr_r] <= held_valid_r ? cls0.res : res_last;
      if (held_valid_r && in_ch.end_of_line) begin
        q_r[wr_ptr_r + 1'b1] <= res_last;
      end
    end
  end

  assign out_ch.out_char    = q_r[rd_ptr_r].ch;
  assign out_ch.token_kind  = q_r[rd_ptr_r].kind;
  assign out_ch.token_begin = q_r[rd_ptr_r].tbeg;
  assign out_ch.token_end   = q_r[rd_ptr_r].tend;
  assign out_ch.line_done   = q_r[rd_ptr_r].line_done;

endmodule

`default_nettype wire

/* src/tll_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module tll_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic [2:0] token_kind,
  input wire logic       token_begin,
  input wire logic       token_end,
  input wire logic       line_done
);

  // A stalled result stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(token_kind) && $stable(token_begin) && $stable(token_end) && $stable(line_done))

  // Skipped characters carry no token marks.
  `ASSERT_SAME(a_skip_unmarked, out_valid && (token_kind == tll_pkg::KIND_WS || token_kind == tll_pkg::KIND_COMMENT), !token_begin && !token_end)

  // A symbol is a complete one-character token.
  `ASSERT_SAME(a_sym_whole, out_valid && token_kind == tll_pkg::KIND_SYM, token_begin && token_end)

  // Nothing is offered right after reset.
  `ASSERT_SAME(a_reset_empty, $past(!rst_n), !out_valid)

endmodule

bind template_line_lexer_unit tll_checker u_tll_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_char    (out_ch.out_char),
  .token_kind  (out_ch.token_kind),
  .token_begin (out_ch.token_begin),
  .token_end   (out_ch.token_end),
  .line_done   (out_ch.line_done)
);

`default_nettype wire
